FILE: rtl/gne3d_pkg.sv
// shared types and constants for the 3d neighbour enumerator
package gne3d_pkg;

  localparam int unsigned CoordW   = 8;
  localparam int unsigned ExtentW  = 9;
  localparam int unsigned WordW    = 32;
  localparam int unsigned NbrW     = 24;
  localparam int unsigned OrdW     = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam int unsigned MaxOrd   = 26;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXTENT_X  = 2'd0,
    REG_EXTENT_Y  = 2'd1,
    REG_EXTENT_Z  = 2'd2,
    REG_INV_MARK  = 2'd3
  } cfg_reg_e;

  // per-axis offset range, offsets coded 0..2 for -1..+1
  typedef struct packed {
    logic [1:0] lo;
    logic [1:0] hi;
  } axis_rng_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } cell_t;

  typedef struct packed {
    cell_t     center;
    axis_rng_t rx;
    axis_rng_t ry;
    axis_rng_t rz;
    logic      none;
  } job_t;

endpackage

FILE: rtl/grid_neighbour_enumerator_3d_core.sv
// top level of the 3d neighbour enumerator: front, job queue and back
// path: a transfer in is written to the job queue, taken into the back's job register
// and written to the result register; throughput: one result per cycle from the back
// walker, held while the result register is full and not popped
// a 2-entry job queue lets the front take items while the back is still walking
// reset: extents 256, invalid marker all ones, queue and result register empty
module grid_neighbour_enumerator_3d_core import gne3d_pkg::*; #(
  parameter int unsigned SECTOR_LIMIT = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  logic [WordW-1:0]    center_word_i,
  output logic                empty,
  input  logic                pop,
  output logic [NbrW-1:0]     neighbour_word_o,
  output logic [OrdW-1:0]     ordinal_o,
  output logic                is_last_o,
  output logic                none_found_o
);

  job_t front_job, head_job;
  logic head_vld, head_pop;

  gne3d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .center_word_i (center_word_i),
    .job_o         (front_job)
  );

  gne3d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_vld),
    .data_o  (head_job)
  );

  gne3d_back #(
    .SECTOR_LIMIT (SECTOR_LIMIT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (head_vld),
    .job_i            (head_job),
    .job_pop_o        (head_pop),
    .empty            (empty),
    .pop              (pop),
    .neighbour_word_o (neighbour_word_o),
    .ordinal_o        (ordinal_o),
    .is_last_o        (is_last_o),
    .none_found_o     (none_found_o)
  );

  a_none_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && none_found_o) |-> (is_last_o && ordinal_o == '0 && neighbour_word_o == '0))
    else $error("none_found result is not a lone zero result");

  a_ord_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (ordinal_o <= OrdW'(MaxOrd)))
    else $error("ordinal beyond neighbourhood size");

  a_ord_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ordinal_o == OrdW'(MaxOrd)) |-> is_last_o)
    else $error("27th result not marked last");

  a_head_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> head_vld)
    else $error("back took a job from an empty queue");

endmodule

FILE: rtl/gne3d_front.sv
// front end: configuration registers and classification of incoming cell words
module gne3d_front import gne3d_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [WordW-1:0]    center_word_i,
  output job_t                job_o
);

  logic [ExtentW-1:0] ext_x_q, ext_y_q, ext_z_q;
  logic [WordW-1:0]   inv_mark_q;
  logic               ok_x, ok_y, ok_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_x_q    <= ExtentW'(256);
      ext_y_q    <= ExtentW'(256);
      ext_z_q    <= ExtentW'(256);
      inv_mark_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_EXTENT_X: ext_x_q    <= cfg_data_i[ExtentW-1:0];
        REG_EXTENT_Y: ext_y_q    <= cfg_data_i[ExtentW-1:0];
        REG_EXTENT_Z: ext_z_q    <= cfg_data_i[ExtentW-1:0];
        REG_INV_MARK: inv_mark_q <= cfg_data_i[WordW-1:0];
        default: ;
      endcase
    end
  end

  function automatic axis_rng_t axis_range(input logic [CoordW-1:0] c,
                                           input logic [ExtentW-1:0] ext,
                                           output logic any);
    logic [ExtentW-1:0] cw;
    logic               v0, v1, v2;
    axis_rng_t          r;
    cw = {1'b0, c};
    v0 = (c != '0) && ((cw - ExtentW'(1)) < ext);
    v1 = cw < ext;
    v2 = (cw + ExtentW'(1)) < ext;
    r.lo = v0 ? 2'd0 : (v1 ? 2'd1 : 2'd2);
    r.hi = v2 ? 2'd2 : (v1 ? 2'd1 : 2'd0);
    any  = v0 | v1 | v2;
    return r;
  endfunction

  always_comb begin
    job_o.center = cell_t'(center_word_i[NbrW-1:0]);
    job_o.rx     = axis_range(center_word_i[23:16], ext_x_q, ok_x);
    job_o.ry     = axis_range(center_word_i[15:8], ext_y_q, ok_y);
    job_o.rz     = axis_range(center_word_i[7:0], ext_z_q, ok_z);
    job_o.none   = (center_word_i == inv_mark_q) || !ok_x || !ok_y || !ok_z;
  end

endmodule

FILE: rtl/gne3d_queue.sv
// short job queue between front and back
module gne3d_queue import gne3d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/gne3d_back.sv
// back end: walks the neighbour offsets of one job and fills the result register
module gne3d_back import gne3d_pkg::*; #(
  parameter int unsigned SECTOR_LIMIT = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [NbrW-1:0]   neighbour_word_o,
  output logic [OrdW-1:0]   ordinal_o,
  output logic              is_last_o,
  output logic              none_found_o
);

  localparam logic [ExtentW-1:0] Limit = ExtentW'(SECTOR_LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  job_t              job_q, job_d;
  logic [1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
  logic [OrdW-1:0]   cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [NbrW-1:0]   word_q, word_d;
  logic [OrdW-1:0]   ord_q, ord_d;
  logic              last_q, last_d, none_q, none_d;
  logic              slot_free, at_end;

  function automatic logic [CoordW-1:0] coord(input logic [CoordW-1:0] c,
                                              input logic [1:0] off);
    logic [ExtentW-1:0] v;
    v = {1'b0, c} + ExtentW'(off) - ExtentW'(1);
    return (v > Limit) ? Limit[CoordW-1:0] : v[CoordW-1:0];
  endfunction

  assign slot_free = !out_vld_q || pop;
  assign at_end    = (i_q == job_q.rx.hi) && (j_q == job_q.ry.hi) && (k_q == job_q.rz.hi);

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    cnt_d     = cnt_q;
    out_vld_d = out_vld_q && !pop;
    word_d    = word_q;
    ord_d     = ord_q;
    last_d    = last_q;
    none_d    = none_q;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          i_d       = job_i.rx.lo;
          j_d       = job_i.ry.lo;
          k_d       = job_i.rz.lo;
          cnt_d     = '0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          if (job_q.none) begin
            word_d  = '0;
            ord_d   = '0;
            last_d  = 1'b1;
            none_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            word_d = {coord(job_q.center.x, i_q), coord(job_q.center.y, j_q),
                      coord(job_q.center.z, k_q)};
            ord_d  = cnt_q;
            last_d = at_end;
            none_d = 1'b0;
            cnt_d  = cnt_q + OrdW'(1);
            if (at_end) begin
              state_d = ST_IDLE;
            end else if (k_q != job_q.rz.hi) begin
              k_d = k_q + 2'd1;
            end else begin
              k_d = job_q.rz.lo;
              if (j_q != job_q.ry.hi) begin
                j_d = j_q + 2'd1;
              end else begin
                j_d = job_q.ry.lo;
                i_d = i_q + 2'd1;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    word_q <= word_d;
    ord_q  <= ord_d;
    last_q <= last_d;
    none_q <= none_d;
  end

  assign empty            = !out_vld_q;
  assign neighbour_word_o = word_q;
  assign ordinal_o        = ord_q;
  assign is_last_o        = last_q;
  assign none_found_o     = none_q;

endmodule
